[rtl/tkh_pkg.sv]
// Shared widths, reset values and the stored entry type for the top-K heap selector.
package tkh_pkg;

  localparam int WEIGHT_W      = 32;
  localparam int ID_W          = 16;
  localparam int KEEP_W        = 5;
  localparam int DEF_MAX_KEEP  = 16;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic [ID_W-1:0]            id;
  } entry_t;

endpackage

[rtl/tkh_ram.sv]
// Heap entry store: one write port, one read port, registered read data.
module tkh_ram #(
  parameter int DEPTH = tkh_pkg::DEF_MAX_KEEP,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  tkh_pkg::entry_t  wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output tkh_pkg::entry_t  rdata
);
  import tkh_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/top_k_min_heap_select.sv]
// Top level of the top-K selector: run control, heap sift-down sequencer and result output.
//
// Keeps the K largest-weight items of each run, K taken from keep_count at the first
// item of the run (0 acts as 1, values above MAX_KEEP saturate). All entries live in
// one single-read-port RAM, so timing is set by that port, and in_stall holds new items
// off until the current one is done: each of the first K items is written straight in;
// the item that triggers heap formation takes the bottom-up build (per node a read and
// a sift down the heap levels) and then the insert; every later item is compared with
// the root and, when it replaces it, sifted down at most log2(K) + 1 levels. On the item
// marked final, the kept entries stream out in array order, one read at a time while
// out_stall allows; a new run may start once the last item sits in the output register.
module top_k_min_heap_select #(
  parameter int MAX_KEEP = tkh_pkg::DEF_MAX_KEEP
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tkh_pkg::KEEP_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tkh_pkg::WEIGHT_W-1:0] item_weight,
  input  logic [tkh_pkg::ID_W-1:0]            item_id,
  input  logic                                final_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tkh_pkg::ID_W-1:0]            kept_id,
  output logic signed [tkh_pkg::WEIGHT_W-1:0] kept_weight,
  output logic                                last_result
);
  import tkh_pkg::*;

  localparam int AW = $clog2(MAX_KEEP);
  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int IW = AW + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HEAP_RD,
    S_HEAP_LD,
    S_SIFT,
    S_LEFT,
    S_RIGHT,
    S_ROOT_RD,
    S_ROOT_CMP,
    S_EMIT
  } state_t;

  state_t          state;
  logic [KEEP_W-1:0] keep_count;
  logic [CW-1:0]   fill;
  logic [CW-1:0]   run_keep;
  logic [CW-1:0]   emit_n;
  logic [CW-1:0]   emit_idx;
  logic            built;
  logic            in_heapify;
  logic            hold_final;
  logic            rd_pending;
  logic [AW-1:0]   heap_idx;
  logic [AW-1:0]   pos;
  entry_t          carry;
  entry_t          hold;
  entry_t          left_e;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  entry_t          ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  entry_t          ram_rdata;

  logic [CW-1:0]   eff_keep;
  logic [CW-1:0]   k_now;
  logic [CW-1:0]   half_k;
  logic            accept;
  logic            store_now;
  logic [IW-1:0]   child_l;
  logic [IW-1:0]   child_r;
  logic [IW-1:0]   size;
  logic            has_l;
  logic            has_r;
  logic            decide;
  entry_t          sel_e;
  logic [IW-1:0]   sel_pos;
  logic            move;
  logic            sift_end;
  logic            root_win;
  logic            finish;
  logic            emit_issue;

  tkh_ram #(
    .DEPTH (MAX_KEEP),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (keep_count == '0) begin
      eff_keep = CW'(1);
    end else if (32'(keep_count) > 32'(MAX_KEEP)) begin
      eff_keep = CW'(MAX_KEEP);
    end else begin
      eff_keep = CW'(keep_count);
    end
    k_now     = (fill == '0 && !built) ? eff_keep : run_keep;
    half_k    = k_now >> 1;
    store_now = !built && (fill < k_now);

    child_l = {1'b0, pos, 1'b1};
    child_r = child_l + IW'(1);
    size    = IW'(run_keep);
    has_l   = child_l < size;
    has_r   = child_r < size;

    if (state == S_RIGHT && left_e.weight > ram_rdata.weight) begin
      sel_e   = ram_rdata;
      sel_pos = child_r;
    end else if (state == S_RIGHT) begin
      sel_e   = left_e;
      sel_pos = child_l;
    end else begin
      sel_e   = ram_rdata;
      sel_pos = child_l;
    end
    decide   = (state == S_LEFT && !has_r) || (state == S_RIGHT);
    move     = decide && (carry.weight > sel_e.weight);
    sift_end = (state == S_SIFT && !has_l) || (decide && !move);
    root_win = hold.weight > ram_rdata.weight;
    finish   = (sift_end && !in_heapify) || (state == S_ROOT_CMP && !root_win);

    emit_issue = (state == S_EMIT) && !rd_pending && (!out_valid || !out_stall)
                 && (emit_idx < emit_n);

    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = carry;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        if (accept && store_now) begin
          ram_we    = 1'b1;
          ram_waddr = fill[AW-1:0];
          ram_wdata = '{weight: item_weight, id: item_id};
        end
      end
      S_HEAP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = heap_idx;
      end
      S_SIFT: begin
        if (has_l) begin
          ram_re    = 1'b1;
          ram_raddr = child_l[AW-1:0];
        end else begin
          ram_we = 1'b1;
        end
      end
      S_LEFT, S_RIGHT: begin
        if (state == S_LEFT && has_r) begin
          ram_re    = 1'b1;
          ram_raddr = child_r[AW-1:0];
        end else if (move) begin
          ram_we    = 1'b1;
          ram_wdata = sel_e;
        end else begin
          ram_we = 1'b1;
        end
      end
      S_ROOT_RD: begin
        ram_re = 1'b1;
      end
      S_EMIT: begin
        ram_re    = emit_issue;
        ram_raddr = emit_idx[AW-1:0];
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      keep_count <= KEEP_RESET;
      fill       <= '0;
      built      <= 1'b0;
      run_keep   <= CW'(1);
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        keep_count <= cfg_data;
      end

      if (rd_pending) begin
        out_valid   <= 1'b1;
        kept_id     <= ram_rdata.id;
        kept_weight <= ram_rdata.weight;
        last_result <= (emit_idx == emit_n);
        rd_pending  <= 1'b0;
        if (emit_idx == emit_n) begin
          state <= S_IDLE;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            run_keep <= k_now;
            if (store_now) begin
              if (final_item) begin
                emit_n   <= fill + CW'(1);
                emit_idx <= '0;
                fill     <= '0;
                built    <= 1'b0;
                state    <= S_EMIT;
              end else begin
                fill <= fill + CW'(1);
              end
            end else begin
              hold       <= '{weight: item_weight, id: item_id};
              hold_final <= final_item;
              if (!built) begin
                heap_idx   <= half_k[AW-1:0];
                in_heapify <= 1'b1;
                state      <= S_HEAP_RD;
              end else begin
                state <= S_ROOT_RD;
              end
            end
          end
        end
        S_HEAP_RD: begin
          state <= S_HEAP_LD;
        end
        S_HEAP_LD: begin
          carry <= ram_rdata;
          pos   <= heap_idx;
          state <= S_SIFT;
        end
        S_SIFT, S_LEFT, S_RIGHT: begin
          if (state == S_SIFT && has_l) begin
            state <= S_LEFT;
          end else if (state == S_LEFT && has_r) begin
            left_e <= ram_rdata;
            state  <= S_RIGHT;
          end else if (move) begin
            pos   <= sel_pos[AW-1:0];
            state <= S_SIFT;
          end else if (in_heapify) begin
            if (heap_idx == '0) begin
              built      <= 1'b1;
              in_heapify <= 1'b0;
              state      <= S_ROOT_RD;
            end else begin
              heap_idx <= heap_idx - AW'(1);
              state    <= S_HEAP_RD;
            end
          end
        end
        S_ROOT_RD: begin
          state <= S_ROOT_CMP;
        end
        S_ROOT_CMP: begin
          if (root_win) begin
            carry      <= hold;
            pos        <= '0;
            in_heapify <= 1'b0;
            state      <= S_SIFT;
          end
        end
        S_EMIT: begin
          if (emit_issue) begin
            emit_idx   <= emit_idx + CW'(1);
            rd_pending <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (finish) begin
        if (hold_final) begin
          emit_n   <= run_keep;
          emit_idx <= '0;
          fill     <= '0;
          built    <= 1'b0;
          state    <= S_EMIT;
        end else begin
          state <= S_IDLE;
        end
      end
    end
  end

endmodule
